// File: src/escf_pkg.sv
// Shared types, constants and the CRC helper for the escaped CRC frame builder.
package escf_pkg;

   localparam int MAX_PAYLOAD_DEF = 5;

   localparam logic [7:0]  MSG_ID     = 8'h02;
   localparam logic [7:0]  ESC_BYTE   = 8'h5C;
   localparam logic [7:0]  LEN_OFFSET = 8'd4;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;

   localparam logic [7:0] START_BYTE_RESET = 8'd126;
   localparam logic [7:0] END_BYTE_RESET   = 8'd127;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_BYTE   = 1'b1;

   // Frame byte slots produced by one input transaction, in emit order
   localparam int NUM_SLOTS  = 10;
   localparam int SLOT_W     = $clog2(NUM_SLOTS);
   localparam int SLOT_START = 0;
   localparam int SLOT_LEN   = 1;
   localparam int SLOT_ID    = 2;
   localparam int SLOT_ESC_P = 3;
   localparam int SLOT_PB    = 4;
   localparam int SLOT_ESC_L = 5;
   localparam int SLOT_CRC_L = 6;
   localparam int SLOT_ESC_H = 7;
   localparam int SLOT_CRC_H = 8;
   localparam int SLOT_END   = 9;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [2:0] payload_length;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       end_of_frame;
   } rsp_type;

   typedef struct packed {
      logic [NUM_SLOTS-1:0]       mask;
      logic [NUM_SLOTS-1:0][7:0] bytes;
   } burst_type;

   // CRC-16/MODBUS update by one byte, reflected
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: src/escf_builder.sv
// Input register, frame state and per-transaction frame byte slot builder.
module escf_builder #(
   parameter int MAX_PAYLOAD = escf_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  escf_pkg::req_type   req_item,
   input  logic [7:0]          start_byte,
   input  logic [7:0]          end_byte,
   output logic                burst_valid,
   input  logic                burst_ready,
   output escf_pkg::burst_type burst
);
   import escf_pkg::*;

   localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

   logic             in_valid_ff, in_valid_in;
   req_type          in_item_ff, in_item_in;
   logic             in_frame_ff, in_frame_in;
   logic [15:0]      crc_ff, crc_in;
   logic [CNT_W-1:0] hdr_len_ff, hdr_len_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             load;
   logic             first;
   logic [7:0]       plen8, max8, plen_sat8, len_byte;
   logic [CNT_W-1:0] hdr_eff, cnt_base, cnt_inc, cnt_after;
   logic             has_pb, last;
   logic [15:0]      crc_base, crc_new;
   logic [7:0]       pb;

   assign burst_valid = in_valid_ff;
   assign load        = in_valid_ff && burst_ready;
   assign req_ready   = !in_valid_ff || load;

   always_comb begin
      pb        = in_item_ff.payload_byte;
      first     = !in_frame_ff;
      plen8     = {5'b0, in_item_ff.payload_length};
      max8      = 8'(MAX_PAYLOAD);
      plen_sat8 = (plen8 > max8) ? max8 : plen8;
      len_byte  = plen_sat8 + LEN_OFFSET;
      hdr_eff   = first ? plen_sat8[CNT_W-1:0] : hdr_len_ff;
      has_pb    = (hdr_eff != '0);
      // header CRC depends only on the saturated length
      crc_base  = first ? crc_feed(crc_feed(CRC_INIT, len_byte), MSG_ID) : crc_ff;
      crc_new   = has_pb ? crc_feed(crc_base, pb) : crc_base;
      cnt_base  = first ? '0 : count_ff;
      cnt_inc   = cnt_base + CNT_W'(1);
      cnt_after = has_pb ? cnt_inc : cnt_base;
      last      = in_item_ff.is_last || (first && (plen_sat8 == 8'd0)) ||
                  (has_pb && (cnt_inc >= hdr_eff));

      burst.mask  = '0;
      burst.bytes = '0;
      burst.mask[SLOT_START]  = first;
      burst.mask[SLOT_LEN]    = first;
      burst.mask[SLOT_ID]     = first;
      burst.mask[SLOT_ESC_P]  = has_pb && ((pb == start_byte) || (pb == end_byte));
      burst.mask[SLOT_PB]     = has_pb;
      burst.mask[SLOT_ESC_L]  = last && ((crc_new[7:0] == start_byte) ||
                                         (crc_new[7:0] == end_byte));
      burst.mask[SLOT_CRC_L]  = last;
      burst.mask[SLOT_ESC_H]  = last && ((crc_new[15:8] == start_byte) ||
                                         (crc_new[15:8] == end_byte));
      burst.mask[SLOT_CRC_H]  = last;
      burst.mask[SLOT_END]    = last;
      burst.bytes[SLOT_START] = start_byte;
      burst.bytes[SLOT_LEN]   = len_byte;
      burst.bytes[SLOT_ID]    = MSG_ID;
      burst.bytes[SLOT_ESC_P] = ESC_BYTE;
      burst.bytes[SLOT_PB]    = pb;
      burst.bytes[SLOT_ESC_L] = ESC_BYTE;
      burst.bytes[SLOT_CRC_L] = crc_new[7:0];
      burst.bytes[SLOT_ESC_H] = ESC_BYTE;
      burst.bytes[SLOT_CRC_H] = crc_new[15:8];
      burst.bytes[SLOT_END]   = end_byte;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      in_frame_in = in_frame_ff;
      crc_in      = crc_ff;
      hdr_len_in  = hdr_len_ff;
      count_in    = count_ff;
      if (load) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_item_in  = req_item;
      end
      if (load) begin
         if (last) begin
            // close the frame
            in_frame_in = 1'b0;
            crc_in      = CRC_INIT;
            hdr_len_in  = '0;
            count_in    = '0;
         end else begin
            in_frame_in = 1'b1;
            crc_in      = crc_new;
            hdr_len_in  = hdr_eff;
            count_in    = cnt_after;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         in_frame_ff <= 1'b0;
         crc_ff      <= CRC_INIT;
         hdr_len_ff  <= '0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         in_frame_ff <= in_frame_in;
         crc_ff      <= crc_in;
         hdr_len_ff  <= hdr_len_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   a_closed_clear : assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> (hdr_len_ff == '0) && (count_ff == '0) && (crc_ff == CRC_INIT))
      else $error("closed frame state not cleared");

   a_open_count : assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> (count_ff < hdr_len_ff))
      else $error("open frame count reached its length");

   a_header_once : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |-> (burst.mask[SLOT_START] == !in_frame_ff))
      else $error("header slot out of step with frame state");

endmodule

// File: src/escf_serializer.sv
// Slot register and output byte register: emits the present slots in order.
module escf_serializer (
   input  logic                clock,
   input  logic                reset,
   input  logic                burst_valid,
   output logic                burst_ready,
   input  escf_pkg::burst_type burst,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output escf_pkg::rsp_type   rsp_item
);
   import escf_pkg::*;

   logic                 slots_valid_ff, slots_valid_in;
   burst_type            slots_ff, slots_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 rsp_free, step, slots_done;
   logic [SLOT_W-1:0]    pick_idx;
   logic [NUM_SLOTS-1:0] pick_oh, mask_rest;

   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign step        = slots_valid_ff && rsp_free;
   assign pick_oh     = slots_ff.mask & (~slots_ff.mask + NUM_SLOTS'(1));
   assign mask_rest   = slots_ff.mask & ~pick_oh;
   assign slots_done  = step && (mask_rest == '0);
   assign burst_ready = !slots_valid_ff || slots_done;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_item    = rsp_ff;

   always_comb begin
      pick_idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (slots_ff.mask[i]) begin
            pick_idx = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      slots_valid_in = slots_valid_ff;
      slots_in       = slots_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (step) begin
         rsp_valid_in          = 1'b1;
         rsp_in.frame_byte     = slots_ff.bytes[pick_idx];
         rsp_in.end_of_frame   = pick_oh[SLOT_END];
         slots_in.mask         = mask_rest;
         if (slots_done) begin
            slots_valid_in = 1'b0;
         end
      end
      // refill in the cycle the last slot moves out
      if (burst_valid && burst_ready) begin
         slots_valid_in = 1'b1;
         slots_in       = burst;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         slots_valid_ff <= slots_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
      rsp_ff   <= rsp_in;
   end

   a_slots_nonempty : assert property (@(posedge clock) disable iff (reset)
      slots_valid_ff |-> (slots_ff.mask != '0))
      else $error("held slot group has no byte left");

   a_step_fills_out : assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("emitted byte did not reach the output register");

   a_one_per_step : assert property (@(posedge clock) disable iff (reset)
      (step && !slots_done) |=>
         slots_valid_ff && ($countones(slots_ff.mask) ==
                            $past($countones(slots_ff.mask)) - 1))
      else $error("slot mask did not drop exactly one byte");

endmodule

// File: src/escaped_crc_frame_builder_core.sv
// Top level of the escaped CRC frame builder: marker registers and datapath.
//
//  channel  | ports                              | moves
//  ---------+------------------------------------+----------------------------------
//  request  | req_valid, req_ready, req_item     | one payload transaction
//  response | rsp_valid, rsp_ready, rsp_item     | one frame byte per transaction
//  config   | csr_wr_en, csr_index, csr_wr_data  | start / end marker write
//
// Each request transaction yields 1 to 10 frame bytes; the block emits one
// frame byte per cycle through its single output byte register, while the
// response is not stalled.
// The first byte of a request passes the input, slot and output byte registers in turn.
// Reset is synchronous: frame closed, CRC at 0xFFFF, markers at defaults.
// A stalled response holds its byte; further requests wait in the input register.
module escaped_crc_frame_builder_core #(
   parameter int MAX_PAYLOAD = escf_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  escf_pkg::req_type                 req_item,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output escf_pkg::rsp_type                 rsp_item,
   input  logic                              csr_wr_en,
   input  logic [escf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [7:0]                        csr_wr_data
);
   import escf_pkg::*;

   logic [7:0] start_byte_ff, start_byte_in;
   logic [7:0] end_byte_ff, end_byte_in;

   logic      burst_valid, burst_ready;
   burst_type burst;

   always_comb begin
      start_byte_in = start_byte_ff;
      end_byte_in   = end_byte_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_START_BYTE: start_byte_in = csr_wr_data;
            CSR_END_BYTE:   end_byte_in   = csr_wr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_BYTE_RESET;
         end_byte_ff   <= END_BYTE_RESET;
      end else begin
         start_byte_ff <= start_byte_in;
         end_byte_ff   <= end_byte_in;
      end
   end

   escf_builder #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_builder (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .start_byte  (start_byte_ff),
      .end_byte    (end_byte_ff),
      .burst_valid (burst_valid),
      .burst_ready (burst_ready),
      .burst       (burst)
   );

   escf_serializer u_serializer (
      .clock       (clock),
      .reset       (reset),
      .burst_valid (burst_valid),
      .burst_ready (burst_ready),
      .burst       (burst),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item)
   );

endmodule
